[design/efc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the elevator FIFO controller.
// No dependencies; every other design file imports this package.
package efc_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int FLOOR_W     = 3;
    localparam int COUNT_W     = 4;
    localparam int POS_W       = 13;
    localparam int STEPS_W     = 10;
    localparam int TICKS_W     = 16;
    localparam int ELAPSED_W   = 17;
    localparam int CLOSE_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [COUNT_W-1:0]   QUEUE_FULL  = COUNT_W'(QUEUE_DEPTH);

    // Register reset values
    localparam logic [COUNT_W-1:0]  RST_FLOORS     = 4'd8;
    localparam logic [STEPS_W-1:0]  RST_STEPS      = 10'd57;
    localparam logic [FLOOR_W-1:0]  RST_START      = 3'd0;
    localparam logic [TICKS_W-1:0]  RST_OPEN_TICKS = 16'd500;
    localparam logic [TICKS_W-1:0]  RST_EXT_TICKS  = 16'd510;
    localparam logic [CLOSE_W-1:0]  RST_CLOSE      = 8'd5;
    localparam logic [POS_W-1:0]    RST_POSITION   = POS_W'(RST_START * RST_STEPS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOORS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE      = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_HALL  = 3'd1,
        OP_CAB   = 3'd2,
        OP_CLOSE = 3'd3,
        OP_EXT   = 3'd4,
        OP_VENT  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HGT_A,
        S_HGT_B,
        S_SEARCH,
        S_EXEC,
        S_FINISH
    } state_t;

    typedef enum logic {
        MUL_CUR,
        MUL_TGT
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     ha_load;
        logic     hb_load;
        logic     search_step;
        logic     exec;
        logic     publish;
    } efc_cmd_t;

    typedef struct packed {
        logic search_done;
    } efc_status_t;

endpackage

[design/efc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine for the elevator FIFO controller.
// Depends on efc_pkg; drives the datapath through efc_cmd_t.
module efc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  efc_pkg::efc_status_t status,
    output efc_pkg::efc_cmd_t    cmd
);
    import efc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_HGT_A;
            S_HGT_A:  state_next = S_HGT_B;
            S_HGT_B:  state_next = S_SEARCH;
            S_SEARCH: if (status.search_done) state_next = S_EXEC;
            S_EXEC:   state_next = S_FINISH;
            S_FINISH: if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:   cmd.load = in_valid;
            S_HGT_A:
            begin
                cmd.mul_sel = MUL_CUR;
                cmd.ha_load = 1'b1;
            end
            S_HGT_B:
            begin
                cmd.mul_sel = MUL_TGT;
                cmd.hb_load = 1'b1;
            end
            S_SEARCH: cmd.search_step = 1'b1;
            S_EXEC:   cmd.exec = 1'b1;
            S_FINISH: cmd.publish = slot_free;
            default:  cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[design/efc_datapath.sv]
`timescale 1ns / 1ps
// Datapath: configuration, cab and door state, call queue, height unit, result register.
// Depends on efc_pkg; steered by efc_ctrl through efc_cmd_t.
module efc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  efc_pkg::efc_cmd_t                 cmd,
    output efc_pkg::efc_status_t              status,
    input  logic [2:0]                        opcode,
    input  logic [efc_pkg::FLOOR_W-1:0]       floor,
    input  logic                              person_in_lift,
    input  logic                              cfg_we,
    input  logic [efc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [efc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [efc_pkg::POS_W-1:0]         cab_position,
    output logic [efc_pkg::FLOOR_W-1:0]       cab_floor,
    output logic                              doors_open,
    output logic                              ventilation_on,
    output logic [efc_pkg::COUNT_W-1:0]       pending_count,
    output logic                              arrived,
    output logic                              call_ignored
);
    import efc_pkg::*;

    // Latched item
    logic [2:0]         op_reg;
    logic [FLOOR_W-1:0] fl_reg;
    logic               person_reg;

    // Configuration
    logic [COUNT_W-1:0] fiu_reg, fiu_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    logic [TICKS_W-1:0] open_ticks_reg, open_ticks_next;
    logic [TICKS_W-1:0] ext_ticks_reg, ext_ticks_next;
    logic [CLOSE_W-1:0] close_reg, close_next;

    // Cab and door state
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [FLOOR_W-1:0]   cur_reg, cur_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 doors_reg, doors_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [ELAPSED_W-1:0] limit_reg, limit_next;
    logic                 extd_reg, extd_next;
    logic                 vent_reg, vent_next;

    // Working registers for one item
    logic [POS_W-1:0]   ha_reg, ha_next;
    logic [POS_W-1:0]   hb_reg, hb_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               dup_reg, dup_next;
    logic               arr_reg, arr_next;
    logic               ign_reg, ign_next;

    logic [FLOOR_W-1:0] queue_mem [QUEUE_DEPTH];
    logic               push_en, pop_en;

    // Height unit
    logic [FLOOR_W-1:0] mul_floor;
    logic [STEPS_W-1:0] mul_steps;
    logic [POS_W-1:0]   mul_prod;

    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W:0]   ext_sum;
    logic [ELAPSED_W-1:0] close_target;
    logic                 floor_ok, push_ok, may_move, cfg_idle, search_done;

    always_comb
    begin
        if (cfg_we)
            mul_floor = (cfg_index == CFG_START) ? cfg_data[FLOOR_W-1:0] : cur_reg;
        else if (cmd.mul_sel == MUL_CUR)
            mul_floor = cur_reg;
        else
            mul_floor = (op_reg == OP_TICK) ? queue_mem[0] : fl_reg;
        mul_steps = (cfg_we && cfg_index == CFG_STEPS) ? cfg_data[STEPS_W-1:0] : steps_reg;
    end

    assign mul_prod = POS_W'(mul_floor) * POS_W'(mul_steps);

    assign search_done        = (idx_reg >= count_reg);
    assign status.search_done = search_done;

    assign elapsed_inc  = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign ext_sum      = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(ext_ticks_reg);
    assign close_target = (limit_reg > ELAPSED_W'(close_reg))
                          ? limit_reg - ELAPSED_W'(close_reg) : '0;
    assign floor_ok     = ({1'b0, fl_reg} < fiu_reg);
    assign push_ok      = !dup_reg && (count_reg < QUEUE_FULL);
    assign cfg_idle     = (count_reg == '0) && !doors_reg;

    always_comb
    begin
        fiu_next        = fiu_reg;
        steps_next      = steps_reg;
        open_ticks_next = open_ticks_reg;
        ext_ticks_next  = ext_ticks_reg;
        close_next      = close_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        doors_next      = doors_reg;
        elapsed_next    = elapsed_reg;
        limit_next      = limit_reg;
        extd_next       = extd_reg;
        vent_next       = vent_reg;
        ha_next         = cmd.ha_load ? mul_prod : ha_reg;
        hb_next         = cmd.hb_load ? mul_prod : hb_reg;
        idx_next        = idx_reg;
        dup_next        = dup_reg;
        arr_next        = arr_reg;
        ign_next        = ign_reg;
        push_en         = 1'b0;
        pop_en          = 1'b0;
        may_move        = 1'b1;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FLOORS:     fiu_next = cfg_data[COUNT_W-1:0];
                CFG_STEPS:
                begin
                    steps_next = cfg_data[STEPS_W-1:0];
                    if (cfg_idle)
                        pos_next = mul_prod;
                end
                CFG_START:
                begin
                    if (cfg_idle)
                    begin
                        cur_next = cfg_data[FLOOR_W-1:0];
                        pos_next = mul_prod;
                    end
                end
                CFG_OPEN_TICKS: open_ticks_next = cfg_data[TICKS_W-1:0];
                CFG_EXT_TICKS:  ext_ticks_next  = cfg_data[TICKS_W-1:0];
                CFG_CLOSE:      close_next      = cfg_data[CLOSE_W-1:0];
                default:        fiu_next        = fiu_reg;
            endcase
        end

        if (cmd.load)
        begin
            idx_next = '0;
            dup_next = 1'b0;
        end

        // Walk the queue one entry per cycle looking for the requested floor
        if (cmd.search_step && !search_done)
        begin
            if (queue_mem[idx_reg[FLOOR_W-1:0]] == fl_reg)
                dup_next = 1'b1;
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.exec)
        begin
            arr_next = 1'b0;
            ign_next = 1'b0;
            case (op_reg)
                OP_TICK:
                begin
                    if (doors_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= limit_reg)
                            doors_next = 1'b0;
                        else
                            may_move = 1'b0;
                    end
                    if (may_move && count_reg != '0)
                    begin
                        if (pos_reg < hb_reg)
                            pos_next = pos_reg + 1'b1;
                        else if (pos_reg > hb_reg)
                            pos_next = pos_reg - 1'b1;
                        else
                        begin
                            cur_next     = queue_mem[0];
                            doors_next   = 1'b1;
                            elapsed_next = '0;
                            limit_next   = ELAPSED_W'(open_ticks_reg);
                            extd_next    = 1'b0;
                            vent_next    = 1'b0;
                            pop_en       = 1'b1;
                            count_next   = count_reg - 1'b1;
                            arr_next     = 1'b1;
                        end
                    end
                end
                OP_HALL:
                begin
                    if (!floor_ok)
                        ign_next = 1'b1;
                    else if (pos_reg == ha_reg && pos_reg == hb_reg)
                    begin
                        if (!doors_reg)
                        begin
                            doors_next   = 1'b1;
                            elapsed_next = '0;
                            limit_next   = ELAPSED_W'(open_ticks_reg);
                            extd_next    = 1'b0;
                        end
                    end
                    else if (push_ok)
                        push_en = 1'b1;
                    else
                        ign_next = 1'b1;
                end
                OP_CAB:
                begin
                    if (!person_reg || !floor_ok)
                        ign_next = 1'b1;
                    else if (fl_reg == cur_reg && doors_reg && count_reg == '0)
                        ign_next = 1'b1;
                    else if (push_ok)
                        push_en = 1'b1;
                    else
                        ign_next = 1'b1;
                end
                OP_CLOSE:
                begin
                    if (!person_reg || !doors_reg)
                        ign_next = 1'b1;
                    else if (elapsed_reg < close_target)
                        elapsed_next = close_target;
                    else
                        ign_next = 1'b1;
                end
                OP_EXT:
                begin
                    if (!person_reg || !doors_reg || extd_reg)
                        ign_next = 1'b1;
                    else
                    begin
                        limit_next = (ext_sum > (ELAPSED_W + 1)'(ELAPSED_MAX))
                                     ? ELAPSED_MAX : ext_sum[ELAPSED_W-1:0];
                        extd_next  = 1'b1;
                    end
                end
                OP_VENT:
                begin
                    if (!person_reg)
                        ign_next = 1'b1;
                    else
                        vent_next = 1'b1;
                end
                default: ign_next = 1'b1;
            endcase
            if (push_en)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg        <= RST_FLOORS;
            steps_reg      <= RST_STEPS;
            open_ticks_reg <= RST_OPEN_TICKS;
            ext_ticks_reg  <= RST_EXT_TICKS;
            close_reg      <= RST_CLOSE;
            pos_reg        <= RST_POSITION;
            cur_reg        <= RST_START;
            count_reg      <= '0;
            doors_reg      <= 1'b0;
            elapsed_reg    <= '0;
            limit_reg      <= ELAPSED_W'(RST_OPEN_TICKS);
            extd_reg       <= 1'b0;
            vent_reg       <= 1'b0;
            idx_reg        <= '0;
            dup_reg        <= 1'b0;
            arr_reg        <= 1'b0;
            ign_reg        <= 1'b0;
        end
        else
        begin
            fiu_reg        <= fiu_next;
            steps_reg      <= steps_next;
            open_ticks_reg <= open_ticks_next;
            ext_ticks_reg  <= ext_ticks_next;
            close_reg      <= close_next;
            pos_reg        <= pos_next;
            cur_reg        <= cur_next;
            count_reg      <= count_next;
            doors_reg      <= doors_next;
            elapsed_reg    <= elapsed_next;
            limit_reg      <= limit_next;
            extd_reg       <= extd_next;
            vent_reg       <= vent_next;
            idx_reg        <= idx_next;
            dup_reg        <= dup_next;
            arr_reg        <= arr_next;
            ign_reg        <= ign_next;
        end
    end

    // Payload and queue storage, no reset
    always_ff @(posedge clk)
    begin
        ha_reg <= ha_next;
        hb_reg <= hb_next;
        if (cmd.load)
        begin
            op_reg     <= opcode;
            fl_reg     <= floor;
            person_reg <= person_in_lift;
        end
        if (push_en)
            queue_mem[count_reg[FLOOR_W-1:0]] <= fl_reg;
        else if (pop_en)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                queue_mem[i] <= queue_mem[i+1];
        end
        if (cmd.publish)
        begin
            cab_position   <= pos_reg;
            cab_floor      <= cur_reg;
            doors_open     <= doors_reg;
            ventilation_on <= vent_reg;
            pending_count  <= count_reg;
            arrived        <= arr_reg;
            call_ignored   <= ign_reg;
        end
    end

endmodule

[design/elevator_fifo_controller.sv]
`timescale 1ns / 1ps
// Top level of the single-cab elevator controller with a FIFO of calls.
// Depends on efc_pkg, efc_ctrl and efc_datapath.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_stall  | opcode, floor, person_in_lift
//  output   | out_valid / out_stall| cab_position, cab_floor, doors_open,
//           |                      | ventilation_on, pending_count, arrived,
//           |                      | call_ignored
//  config   | cfg_we               | cfg_index, cfg_data
//
// An item passes from acceptance to the next acceptance through load, two passes
// through the shared floor-height multiplier, a duplicate search that visits one
// queued floor per cycle, execute and publish. Reset is asynchronous and active
// low; no clearing pass is needed, since queue entries above the fill count are
// never used. A stalled result waits in the output register; a new item is still
// accepted and held at publish until the register frees.
module elevator_fifo_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input item channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        opcode,
    input  logic [efc_pkg::FLOOR_W-1:0]       floor,
    input  logic                              person_in_lift,
    // Result item channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [efc_pkg::POS_W-1:0]         cab_position,
    output logic [efc_pkg::FLOOR_W-1:0]       cab_floor,
    output logic                              doors_open,
    output logic                              ventilation_on,
    output logic [efc_pkg::COUNT_W-1:0]       pending_count,
    output logic                              arrived,
    output logic                              call_ignored,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [efc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [efc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import efc_pkg::*;

    efc_cmd_t    cmd;
    efc_status_t status;

    // Sequencer: accept, step through height, search, execute, publish
    efc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: holds configuration, cab state, call queue and result register
    efc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (opcode),
        .floor          (floor),
        .person_in_lift (person_in_lift),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cab_position   (cab_position),
        .cab_floor      (cab_floor),
        .doors_open     (doors_open),
        .ventilation_on (ventilation_on),
        .pending_count  (pending_count),
        .arrived        (arrived),
        .call_ignored   (call_ignored)
    );

endmodule

[design/efc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the elevator FIFO controller, bound to the top level.
// Depends on efc_pkg and elevator_fifo_controller.
module efc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [efc_pkg::POS_W-1:0]       cab_position,
    input  logic [efc_pkg::FLOOR_W-1:0]     cab_floor,
    input  logic                            doors_open,
    input  logic                            ventilation_on,
    input  logic [efc_pkg::COUNT_W-1:0]     pending_count,
    input  logic                            arrived,
    input  logic                            call_ignored
);
    import efc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cab_position)
            && $stable(cab_floor) && $stable(pending_count) && $stable(arrived))
        else $error("stalled result changed");

    // One item at a time: the cycle after acceptance stalls the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while one is in progress");

    // An arrival opens the doors, drops ventilation and is never an ignored call
    a_arrival: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && arrived |-> doors_open && !ventilation_on && !call_ignored)
        else $error("inconsistent arrival result");

    // Queue never reports more floors than it holds
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_count <= QUEUE_FULL)
        else $error("pending count beyond queue depth");

endmodule

bind elevator_fifo_controller efc_checker u_efc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cab_position   (cab_position),
    .cab_floor      (cab_floor),
    .doors_open     (doors_open),
    .ventilation_on (ventilation_on),
    .pending_count  (pending_count),
    .arrived        (arrived),
    .call_ignored   (call_ignored)
);
